// ----- sv/u8cp_pkg.sv -----
`default_nettype none

package u8cp_pkg;

    localparam int unsigned CpWidth = 21;

    localparam logic [CpWidth-1:0] ReplChar  = 21'h00fffd;
    localparam logic [CpWidth-1:0] ScalarMax = 21'h10ffff;
    localparam logic [CpWidth-1:0] SurrLo    = 21'h00d800;
    localparam logic [CpWidth-1:0] SurrHi    = 21'h00dfff;

    localparam logic [7:0] ContMask  = 8'hc0;
    localparam logic [7:0] ContTag   = 8'h80;
    localparam logic [7:0] Lead2Mask = 8'he0;
    localparam logic [7:0] Lead2Tag  = 8'hc0;
    localparam logic [7:0] Lead3Mask = 8'hf0;
    localparam logic [7:0] Lead3Tag  = 8'he0;
    localparam logic [7:0] Lead4Mask = 8'hf8;
    localparam logic [7:0] Lead4Tag  = 8'hf0;
    localparam logic [7:0] Lead2Bits = 8'h1f;
    localparam logic [7:0] Lead3Bits = 8'h0f;
    localparam logic [7:0] Lead4Bits = 8'h07;
    localparam logic [7:0] ContBits  = 8'h3f;

    // pending multi-byte sequence
    typedef struct packed {
        logic [1:0]         expected;
        logic [1:0]         taken;
        logic [CpWidth-1:0] partial;
    } t_seq;

    // results produced by one byte: a run of replacements, then an optional final result
    typedef struct packed {
        logic [1:0]         rep_cnt;
        logic               fin_vld;
        logic [CpWidth-1:0] fin_cp;
        logic               fin_repl;
        logic               fin_ok;
        logic               fin_last;
    } t_burst;

    function automatic logic is_scalar(input logic [CpWidth-1:0] v);
        return (v <= ScalarMax) && ((v < SurrLo) || (v > SurrHi));
    endfunction

endpackage

`default_nettype wire

// ----- sv/u8cp_ifs.sv -----
`default_nettype none

interface u8cp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8cp_cp_if;
    logic                          valid;
    logic                          ready;
    logic [u8cp_pkg::CpWidth-1:0]  code_point;
    logic                          replaced;
    logic                          scalar_ok;
    logic                          last;

    modport source (output valid, output code_point, output replaced,
                    output scalar_ok, output last, input ready);
    modport sink   (input valid, input code_point, input replaced,
                    input scalar_ok, input last, output ready);
endinterface

`default_nettype wire

// ----- sv/u8cp_decode.sv -----
`default_nettype none

module u8cp_decode (
    input  wire u8cp_pkg::t_seq   i_seq,
    input  wire logic [7:0]       i_byte,
    output u8cp_pkg::t_seq        o_seq,
    output u8cp_pkg::t_burst      o_burst
);

    logic                            is_cont;
    logic [1:0]                      taken_inc;
    logic [u8cp_pkg::CpWidth-1:0]    acc;

    always_comb begin
        is_cont   = (i_byte & u8cp_pkg::ContMask) == u8cp_pkg::ContTag;
        taken_inc = i_seq.taken + 2'd1;
        acc       = {i_seq.partial[u8cp_pkg::CpWidth-7:0], i_byte[5:0]};

        o_seq            = i_seq;
        o_burst.rep_cnt  = 2'd0;
        o_burst.fin_vld  = 1'b0;
        o_burst.fin_cp   = u8cp_pkg::ReplChar;
        o_burst.fin_repl = 1'b0;
        o_burst.fin_ok   = 1'b1;
        o_burst.fin_last = 1'b0;

        if ((i_seq.expected != 2'd0) && is_cont) begin
            // continuation of a pending sequence
            o_seq.partial = acc;
            o_seq.taken   = taken_inc;
            if (taken_inc == i_seq.expected) begin
                o_burst.fin_vld = 1'b1;
                o_burst.fin_cp  = acc;
                o_burst.fin_ok  = u8cp_pkg::is_scalar(acc);
                o_seq           = '0;
            end
        end else begin
            if (i_seq.expected != 2'd0) begin
                // broken sequence: lead plus each taken continuation
                o_burst.rep_cnt = (i_seq.taken == 2'd3) ? 2'd3 : taken_inc;
                o_seq           = '0;
            end
            priority if (i_byte == 8'd0) begin
                o_burst.fin_vld  = 1'b1;
                o_burst.fin_cp   = '0;
                o_burst.fin_last = 1'b1;
            end else if (!i_byte[7]) begin
                o_burst.fin_vld = 1'b1;
                o_burst.fin_cp  = {{(u8cp_pkg::CpWidth-8){1'b0}}, i_byte};
            end else if ((i_byte & u8cp_pkg::Lead2Mask) == u8cp_pkg::Lead2Tag) begin
                o_seq.expected = 2'd1;
                o_seq.partial  = {{(u8cp_pkg::CpWidth-8){1'b0}},
                                  i_byte & u8cp_pkg::Lead2Bits};
            end else if ((i_byte & u8cp_pkg::Lead3Mask) == u8cp_pkg::Lead3Tag) begin
                o_seq.expected = 2'd2;
                o_seq.partial  = {{(u8cp_pkg::CpWidth-8){1'b0}},
                                  i_byte & u8cp_pkg::Lead3Bits};
            end else if ((i_byte & u8cp_pkg::Lead4Mask) == u8cp_pkg::Lead4Tag) begin
                o_seq.expected = 2'd3;
                o_seq.partial  = {{(u8cp_pkg::CpWidth-8){1'b0}},
                                  i_byte & u8cp_pkg::Lead4Bits};
            end else begin
                // lone continuation or lead 0xf8-0xff
                o_burst.fin_vld  = 1'b1;
                o_burst.fin_repl = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/utf8_to_codepoint_decoder.sv -----
`default_nettype none

// a result is registered and shows on the output in the cycle after its byte is transferred
// throughput: one byte per cycle while the output is ready; a byte giving several results
//   holds the input while the single result register drains them, one item per ready cycle
// reset: synchronous active-low i_rst_n clears the pending sequence and the result burst
module utf8_to_codepoint_decoder (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    u8cp_byte_if.sink    i_in,
    u8cp_cp_if.source    o_out
);

    // decoder state and the burst of results waiting to go out
    u8cp_pkg::t_seq   r_seq, n_seq;
    u8cp_pkg::t_burst r_burst, n_burst;

    // step of the decoder for the byte on the input
    u8cp_pkg::t_seq   dec_seq;
    u8cp_pkg::t_burst dec_burst;

    logic burst_empty;
    logic one_left;
    logic out_fire;
    logic in_fire;

    u8cp_decode u_decode (
        .i_seq   (r_seq),
        .i_byte  (i_in.in_byte),
        .o_seq   (dec_seq),
        .o_burst (dec_burst)
    );

    always_comb begin
        burst_empty = (r_burst.rep_cnt == 2'd0) && !r_burst.fin_vld;
        // exactly one result left in the burst
        one_left    = ((r_burst.rep_cnt == 2'd0) && r_burst.fin_vld) ||
                      ((r_burst.rep_cnt == 2'd1) && !r_burst.fin_vld);

        // output comes straight from the burst register: replacements first
        o_out.valid = !burst_empty;
        if (r_burst.rep_cnt != 2'd0) begin
            o_out.code_point = u8cp_pkg::ReplChar;
            o_out.replaced   = 1'b1;
            o_out.scalar_ok  = 1'b1;
            o_out.last       = 1'b0;
        end else begin
            o_out.code_point = r_burst.fin_cp;
            o_out.replaced   = r_burst.fin_repl;
            o_out.scalar_ok  = r_burst.fin_ok;
            o_out.last       = r_burst.fin_last;
        end
        out_fire = o_out.valid && o_out.ready;

        // take a new byte when the burst is empty or its last item leaves this cycle
        i_in.ready = burst_empty || (one_left && o_out.ready);
        in_fire    = i_in.valid && i_in.ready;

        n_seq   = r_seq;
        n_burst = r_burst;
        if (in_fire) begin
            n_seq   = dec_seq;
            n_burst = dec_burst;
        end else if (out_fire) begin
            if (r_burst.rep_cnt != 2'd0) begin
                n_burst.rep_cnt = r_burst.rep_cnt - 2'd1;
            end else begin
                n_burst.fin_vld = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= '0;
            r_burst <= '0;
        end else begin
            r_seq   <= n_seq;
            r_burst <= n_burst;
        end
    end

endmodule

`default_nettype wire

// ----- tb/u8cp_decode_checker.sv -----
`timescale 1ns / 100ps

module u8cp_decode_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_byte_valid,
    input  wire logic                         i_byte_ready,
    input  wire logic [7:0]                   i_byte,
    input  wire logic                         i_cp_valid,
    input  wire logic                         i_cp_ready,
    input  wire logic [u8cp_pkg::CpWidth-1:0] i_code_point,
    input  wire logic                         i_replaced,
    input  wire logic                         i_scalar_ok,
    input  wire logic                         i_last,
    output int                                o_err_cnt,
    output int                                o_pending,
    output int                                o_cp_cnt,
    output int                                o_repl_cnt
);

    typedef struct packed {
        logic [u8cp_pkg::CpWidth-1:0] cp;
        logic                         repl;
        logic                         ok;
        logic                         last;
    } t_cp_item;

    t_cp_item                     cp_expect_q[$];
    t_cp_item                     exp_item;
    logic [1:0]                   seq_need;
    logic [1:0]                   seq_got;
    logic [u8cp_pkg::CpWidth-1:0] seq_acc;
    int                           err_cnt;
    int                           cp_cnt;
    int                           repl_cnt;

    function automatic t_cp_item make_item(input logic [u8cp_pkg::CpWidth-1:0] cp,
                                           input logic repl, input logic last);
        t_cp_item item;
        item.cp   = cp;
        item.repl = repl;
        item.ok   = (cp <= u8cp_pkg::ScalarMax) &&
                    ((cp < u8cp_pkg::SurrLo) || (cp > u8cp_pkg::SurrHi));
        item.last = last;
        return item;
    endfunction

    task automatic clear_seq();
        seq_need = 2'd0;
        seq_got  = 2'd0;
        seq_acc  = '0;
    endtask

    // expected code points for one transferred byte
    task automatic decode_byte(input logic [7:0] b);
        int k;
        if (seq_need != 2'd0) begin
            if ((b & u8cp_pkg::ContMask) == u8cp_pkg::ContTag) begin
                seq_acc = {seq_acc[u8cp_pkg::CpWidth-7:0], b[5:0]};
                seq_got = seq_got + 2'd1;
                if (seq_got == seq_need) begin
                    cp_expect_q.push_back(make_item(seq_acc, 1'b0, 1'b0));
                    clear_seq();
                end
                return;
            end
            // broken sequence: lead and every taken continuation are replaced
            for (k = 0; k <= int'(seq_got) && k < 3; k++)
                cp_expect_q.push_back(make_item(u8cp_pkg::ReplChar, 1'b1, 1'b0));
            clear_seq();
        end
        if (b == 8'h00) begin
            cp_expect_q.push_back(make_item('0, 1'b0, 1'b1));
        end else if (b < u8cp_pkg::ContTag) begin
            cp_expect_q.push_back(make_item(u8cp_pkg::CpWidth'(b), 1'b0, 1'b0));
        end else if ((b & u8cp_pkg::Lead2Mask) == u8cp_pkg::Lead2Tag) begin
            seq_need = 2'd1;
            seq_acc  = u8cp_pkg::CpWidth'(b & u8cp_pkg::Lead2Bits);
        end else if ((b & u8cp_pkg::Lead3Mask) == u8cp_pkg::Lead3Tag) begin
            seq_need = 2'd2;
            seq_acc  = u8cp_pkg::CpWidth'(b & u8cp_pkg::Lead3Bits);
        end else if ((b & u8cp_pkg::Lead4Mask) == u8cp_pkg::Lead4Tag) begin
            seq_need = 2'd3;
            seq_acc  = u8cp_pkg::CpWidth'(b & u8cp_pkg::Lead4Bits);
        end else begin
            cp_expect_q.push_back(make_item(u8cp_pkg::ReplChar, 1'b1, 1'b0));
        end
    endtask

    task automatic check_field(input string name,
                               input logic [u8cp_pkg::CpWidth-1:0] exp_v,
                               input logic [u8cp_pkg::CpWidth-1:0] got_v);
        if (got_v !== exp_v) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_seq();
            cp_expect_q.delete();
        end else begin
            if (i_byte_valid && i_byte_ready)
                decode_byte(i_byte);
            if (i_cp_valid && i_cp_ready) begin
                cp_cnt++;
                if (cp_expect_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected code point, expected none, got 0x%0h",
                             $time, i_code_point);
                end else begin
                    exp_item = cp_expect_q.pop_front();
                    if (exp_item.repl)
                        repl_cnt++;
                    check_field("code_point", exp_item.cp, i_code_point);
                    check_field("replaced", u8cp_pkg::CpWidth'(exp_item.repl),
                                u8cp_pkg::CpWidth'(i_replaced));
                    check_field("scalar_ok", u8cp_pkg::CpWidth'(exp_item.ok),
                                u8cp_pkg::CpWidth'(i_scalar_ok));
                    check_field("last", u8cp_pkg::CpWidth'(exp_item.last),
                                u8cp_pkg::CpWidth'(i_last));
                end
            end
        end
        o_err_cnt  <= err_cnt;
        o_pending  <= cp_expect_q.size();
        o_cp_cnt   <= cp_cnt;
        o_repl_cnt <= repl_cnt;
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    logic        i_clk;
    logic        i_rst_n;

    // idle shaping: chance in a hundred per cycle
    int unsigned send_idle_pct;
    int unsigned sink_stall_pct;

    int          bytes_sent;
    int          err_cnt;
    int          pending;
    int          cp_cnt;
    int          repl_cnt;

    u8cp_byte_if byte_if ();
    u8cp_cp_if   cp_if ();

    utf8_to_codepoint_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if),
        .o_out   (cp_if)
    );

    // prediction and comparison live in the checker, this module only drives
    u8cp_decode_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (byte_if.valid),
        .i_byte_ready (byte_if.ready),
        .i_byte       (byte_if.in_byte),
        .i_cp_valid   (cp_if.valid),
        .i_cp_ready   (cp_if.ready),
        .i_code_point (cp_if.code_point),
        .i_replaced   (cp_if.replaced),
        .i_scalar_ok  (cp_if.scalar_ok),
        .i_last       (cp_if.last),
        .o_err_cnt    (err_cnt),
        .o_pending    (pending),
        .o_cp_cnt     (cp_cnt),
        .o_repl_cnt   (repl_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver side: random back-pressure on the code point channel
    always @(posedge i_clk) begin
        cp_if.ready <= i_rst_n && ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // one byte transfer; valid stays high across back-to-back bytes,
    // it only drops when the sender chooses to idle
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            byte_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_if.valid   <= 1'b1;
        byte_if.in_byte <= b;
        do
            @(posedge i_clk);
        while (!byte_if.ready);
        bytes_sent++;
    endtask

    // lead byte of a 2-, 3- or 4-byte sequence with random payload bits
    function automatic logic [7:0] rand_lead(input int len);
        case (len)
            2: begin
                return u8cp_pkg::Lead2Tag | 8'($urandom_range(0, u8cp_pkg::Lead2Bits));
            end
            3: begin
                return u8cp_pkg::Lead3Tag | 8'($urandom_range(0, u8cp_pkg::Lead3Bits));
            end
            default: begin
                return u8cp_pkg::Lead4Tag | 8'($urandom_range(0, u8cp_pkg::Lead4Bits));
            end
        endcase
    endfunction

    // lead plus n_cont continuation bytes; n_cont = len-1 is a whole character
    task automatic send_seq(input int len, input int n_cont);
        send_byte(rand_lead(len));
        repeat (n_cont)
            send_byte(u8cp_pkg::ContTag | 8'($urandom_range(0, u8cp_pkg::ContBits)));
    endtask

    // mostly well-formed characters with random content, plus terminators,
    // raw noise and sequences cut short by a non-continuation byte
    task automatic random_stream(input int n_bytes);
        int          stop_at;
        int          len;
        logic [7:0]  b;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    send_byte(8'($urandom_range(1, 127)));
                end
                2, 3: begin
                    send_seq(2, 1);
                end
                4: begin
                    send_seq(3, 2);
                end
                5, 6: begin
                    send_seq(4, 3);
                end
                7: begin
                    send_byte(8'h00);
                end
                8: begin
                    send_byte(8'($urandom_range(0, 255)));
                end
                default: begin
                    // broken sequence: the cutting byte is anything but a continuation
                    len = $urandom_range(2, 4);
                    send_seq(len, $urandom_range(0, len - 2));
                    b = 8'($urandom_range(0, 191));
                    if (b >= u8cp_pkg::ContTag)
                        b = b + 8'h40;
                    send_byte(b);
                end
            endcase
        end
    endtask

    initial begin
        byte_if.valid   <= 1'b0;
        byte_if.in_byte <= 8'h00;
        i_rst_n         <= 1'b0;
        send_idle_pct   = 10;
        sink_stall_pct  = 75;
        bytes_sent      = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: terminator and ascii extremes
        send_byte(8'h00);
        send_byte(8'h7f);
        // two- and three-byte characters
        send_byte(8'hc2);
        send_byte(8'ha9);
        send_byte(8'he2);
        send_byte(8'h82);
        send_byte(8'hac);
        // largest four-byte value, beyond the unicode range
        send_byte(8'hf7);
        send_byte(8'hbf);
        send_byte(8'hbf);
        send_byte(8'hbf);
        // surrogate passes through but is not a scalar value
        send_byte(8'hed);
        send_byte(8'ha0);
        send_byte(8'h80);
        // lone continuation and the invalid leads
        send_byte(8'h80);
        send_byte(8'hff);
        send_byte(8'hf8);
        // four-byte sequence cut after two continuations by an ascii byte
        send_byte(8'hf0);
        send_byte(8'h90);
        send_byte(8'h80);
        send_byte(8'h41);
        // zero byte in the middle of a sequence: replacement, then terminator
        send_byte(8'he0);
        send_byte(8'h00);

        // random, sender mostly busy and receiver stalling hard
        random_stream(30);

        // random, sender idling hard and receiver mostly ready
        send_idle_pct  <= 75;
        sink_stall_pct <= 10;
        random_stream(28);

        // random, full rate on both sides
        send_idle_pct  <= 0;
        sink_stall_pct <= 0;
        random_stream(28);

        byte_if.valid <= 1'b0;
        // let the checker count the last transfer before looking at its backlog
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        // then wait on to catch any stray result
        repeat (8) @(posedge i_clk);

        $display("tb_top: %0d bytes fed, %0d code points compared, %0d replacements",
                 bytes_sent, cp_cnt, repl_cnt);
        $display("tb_top: covered valid 1-4 byte chars, bad leads, cut sequences,");
        $display("tb_top: and idle/stall mixes on both channels");
        if (err_cnt == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #(400_000);
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
